### hw/rtl/eit_pkg.sv
// ----------------------------------------------------------------------------
// eit_pkg
// Shared types and codes of the event interest table: request and response
// items, slot entry layout, status and operation codes, and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package eit_pkg;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_MOD = 3'd1;
    localparam logic [2:0] OP_DEL = 3'd2;
    localparam logic [2:0] OP_WAIT = 3'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_BADFD = 3'd1;
    localparam logic [2:0] ST_FAULT = 3'd2;
    localparam logic [2:0] ST_EXIST = 3'd3;
    localparam logic [2:0] ST_NOSPC = 3'd4;
    localparam logic [2:0] ST_NOENT = 3'd5;
    localparam logic [2:0] ST_INVAL = 3'd6;

    localparam logic [6:0] MAX_LIMIT = 7'd64;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] fd;
        logic        fd_open;
        logic        event_absent;
        logic        copy_fault;
        logic [31:0] event_mask;
        logic [63:0] user_word;
        logic [6:0]  max_events;
        logic        dest_missing;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        has_event;
        logic [31:0] out_mask;
        logic [63:0] out_word;
        logic [6:0]  count;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [15:0] fd;
        logic [31:0] mask;
        logic [63:0] word;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       req_load;
        logic       scan_clear;
        logic       lk_step;
        logic       rd_issue;
        logic       idx_inc;
        logic       emit_simple;
        logic [2:0] emit_code;
        logic       emit_ctl;
        logic       emit_entry;
    } eit_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       pre_fail;
        logic [2:0] pre_code;
        logic       is_wait;
        logic       lk_end;
        logic       rest_any;
        logic       cur_used;
        logic       out_free;
        logic       entry_last;
    } eit_sts_t;

endpackage

### hw/rtl/event_interest_table_core.sv
// ----------------------------------------------------------------------------
// event_interest_table_core
// Interest table of SLOTS entries (descriptor, event mask, user word) with
// add, modify, delete and wait requests over valid/ready channels.
// ----------------------------------------------------------------------------
// One request item is taken at a time. A control request (add, modify,
// delete) runs through accept, decode, a lookup scan that reads the slot
// memory one entry per cycle for the descriptor lookup and the lowest free
// slot, a drain state for the last read to return, and a state that
// commits the change and loads the response. Requests that fail their early
// checks (closed descriptor, faulted record, unknown code, invalid wait)
// go from decode to a state that loads their response. A wait walks the
// used bitmap from slot 0 upward, skipping unused slots one per cycle, and
// reads each reported entry from the memory in a separate load state. The
// slot memory has a single read port. The response leaves through an output
// register, so a new request is accepted while the last result waits, and
// a stalled response channel holds a wait scan until its register frees.
// Slot contents have no reset; of the slot state only the used bitmap is
// cleared by reset, and only the entries of used slots are ever matched or
// reported.
module event_interest_table_core
    import eit_pkg::*;
#(
    parameter int SLOTS = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  in_item_t  req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output out_item_t rsp
);

    // Controller and datapath talk only through these two groups.
    eit_cmd_t cmd;
    eit_sts_t sts;

    eit_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    eit_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

### hw/rtl/eit_datapath.sv
// ----------------------------------------------------------------------------
// eit_datapath
// Slot memory, used bitmap, scan index and counters, lookup results and the
// response register of the event interest table.
// ----------------------------------------------------------------------------
module eit_datapath
    import eit_pkg::*;
#(
    parameter int SLOTS = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  req,
    input  logic      rsp_ready,
    input  eit_cmd_t  cmd,
    output eit_sts_t  sts,
    output logic      rsp_valid,
    output out_item_t rsp
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    entry_t mem [SLOTS];

    in_item_t         req_reg;
    entry_t           rd_data_reg;
    logic             rd_valid_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [6:0]       cnt_reg, cnt_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] found_idx_reg, found_idx_next;
    logic             free_reg, free_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic [SLOTS-1:0] used_reg, used_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg, out_next;

    logic [31:0]      new_mask;
    logic [63:0]      new_word;
    logic [2:0]       ctl_status;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [SLOTS-1:0] ge_mask;
    logic [6:0]       limit;
    logic [6:0]       cnt_inc;
    logic             load;
    logic             is_wait;
    logic             pre_fail;
    logic [2:0]       pre_code;
    logic             lk_end;
    logic             rest_any;
    logic             cur_used;
    logic             out_free;
    logic             entry_last;

    assign new_mask = req_reg.event_absent ? 32'd0 : req_reg.event_mask;
    assign new_word = req_reg.event_absent ? 64'd0 : req_reg.user_word;
    assign limit = (req_reg.max_events > MAX_LIMIT) ? MAX_LIMIT : req_reg.max_events;
    assign cnt_inc = 7'(cnt_reg + 7'd1);
    assign ge_mask = {SLOTS{1'b1}} << idx_reg;
    assign load = cmd.emit_simple | cmd.emit_ctl | cmd.emit_entry;
    assign is_wait = (req_reg.op == OP_WAIT);

    // Checks that settle a request before any table access.
    always_comb
    begin
        pre_fail = 1'b0;
        pre_code = ST_INVAL;
        if (is_wait)
        begin
            pre_fail = req_reg.dest_missing || (req_reg.max_events == 7'd0);
        end
        else if (!req_reg.fd_open)
        begin
            pre_fail = 1'b1;
            pre_code = ST_BADFD;
        end
        else if (!req_reg.event_absent && req_reg.copy_fault)
        begin
            pre_fail = 1'b1;
            pre_code = ST_FAULT;
        end
        else if (!(req_reg.op inside {OP_ADD, OP_MOD, OP_DEL}))
        begin
            pre_fail = 1'b1;
        end
    end

    assign lk_end = (idx_reg == LAST_IDX);
    assign rest_any = |(used_reg & ge_mask);
    assign cur_used = used_reg[idx_reg];
    assign out_free = !out_valid_reg || rsp_ready;
    assign entry_last = (cnt_inc == limit) || !(|(used_reg & (ge_mask << 1)));

    assign sts = '{pre_fail: pre_fail, pre_code: pre_code, is_wait: is_wait,
                   lk_end: lk_end, rest_any: rest_any, cur_used: cur_used,
                   out_free: out_free, entry_last: entry_last};

    // Outcome of add, modify and delete once the lookup has finished.
    always_comb
    begin
        ctl_status = ST_OK;
        wr_addr = found_idx_reg;
        case (req_reg.op)
            OP_ADD:
            begin
                wr_addr = free_idx_reg;
                if (found_reg)
                    ctl_status = ST_EXIST;
                else if (!free_reg)
                    ctl_status = ST_NOSPC;
            end
            OP_MOD, OP_DEL:
            begin
                if (!found_reg)
                    ctl_status = ST_NOENT;
            end
            default:
            begin
                ctl_status = ST_INVAL;
            end
        endcase
        wr_en = cmd.emit_ctl && (ctl_status == ST_OK)
                && (req_reg.op == OP_ADD || req_reg.op == OP_MOD);
    end

    always_comb
    begin
        idx_next = idx_reg;
        cnt_next = cnt_reg;
        found_next = found_reg;
        found_idx_next = found_idx_reg;
        free_next = free_reg;
        free_idx_next = free_idx_reg;
        used_next = used_reg;
        if (cmd.scan_clear)
        begin
            idx_next = '0;
            cnt_next = '0;
            found_next = 1'b0;
            free_next = 1'b0;
        end
        if (cmd.lk_step)
        begin
            idx_next = IDX_W'(idx_reg + 1'b1);
            if (!free_reg && !used_reg[idx_reg])
            begin
                free_next = 1'b1;
                free_idx_next = idx_reg;
            end
        end
        // The highest matching slot wins, so later matches overwrite.
        if (rd_valid_reg && used_reg[rd_idx_reg] && rd_data_reg.fd == req_reg.fd)
        begin
            found_next = 1'b1;
            found_idx_next = rd_idx_reg;
        end
        if (cmd.idx_inc)
            idx_next = IDX_W'(idx_reg + 1'b1);
        if (cmd.emit_entry)
            cnt_next = cnt_inc;
        if (cmd.emit_ctl && ctl_status == ST_OK)
        begin
            if (req_reg.op == OP_ADD)
                used_next = used_reg | (SLOTS'(1) << free_idx_reg);
            else if (req_reg.op == OP_DEL)
                used_next = used_reg & ~(SLOTS'(1) << found_idx_reg);
        end
    end

    always_comb
    begin
        out_next = out_reg;
        if (cmd.emit_simple)
            out_next = '{status: cmd.emit_code, has_event: 1'b0, out_mask: '0,
                         out_word: '0, count: '0, last: 1'b1};
        else if (cmd.emit_ctl)
            out_next = '{status: ctl_status, has_event: 1'b0, out_mask: '0,
                         out_word: '0, count: '0, last: 1'b1};
        else if (cmd.emit_entry)
            out_next = '{status: ST_OK, has_event: 1'b1, out_mask: rd_data_reg.mask,
                         out_word: rd_data_reg.word, count: cnt_inc,
                         last: entry_last};
        if (load)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            cnt_reg <= '0;
            found_reg <= 1'b0;
            free_reg <= 1'b0;
            used_reg <= '0;
            rd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
            found_reg <= found_next;
            free_reg <= free_next;
            used_reg <= used_next;
            rd_valid_reg <= cmd.lk_step;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
            req_reg <= req;
        found_idx_reg <= found_idx_next;
        free_idx_reg <= free_idx_next;
        rd_idx_reg <= idx_reg;
        out_reg <= out_next;
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= '{fd: req_reg.fd, mask: new_mask, word: new_word};
        if (cmd.lk_step || cmd.rd_issue)
            rd_data_reg <= mem[idx_reg];
    end

    assign rsp_valid = out_valid_reg;
    assign rsp = out_reg;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> out_free)
        else $error("response register loaded while a result is still held");

    a_write_used: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> used_reg[$past(wr_addr)])
        else $error("slot written but not marked used");

    a_issue_used: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |-> (used_reg[idx_reg] && out_free))
        else $error("wait read issued on a free slot or a full response register");

endmodule

### hw/rtl/eit_ctrl.sv
// ----------------------------------------------------------------------------
// eit_ctrl
// Sequencer of the event interest table: accepts a request, runs the lookup
// one slot per cycle or the wait scan, and orders the datapath to emit results.
// ----------------------------------------------------------------------------
module eit_ctrl
    import eit_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  eit_sts_t sts,
    output eit_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_LSCAN,
        S_LDRAIN,
        S_LACT,
        S_EMIT,
        S_WSCAN,
        S_WLOAD
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] code_reg, code_next;

    always_comb
    begin
        state_next = state_reg;
        code_next = code_reg;
        cmd = '0;
        req_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.req_load = 1'b1;
                    cmd.scan_clear = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.pre_fail)
                begin
                    code_next = sts.pre_code;
                    state_next = S_EMIT;
                end
                else if (sts.is_wait)
                    state_next = S_WSCAN;
                else
                    state_next = S_LSCAN;
            end
            S_LSCAN:
            begin
                cmd.lk_step = 1'b1;
                if (sts.lk_end)
                    state_next = S_LDRAIN;
            end
            S_LDRAIN:
            begin
                state_next = S_LACT;
            end
            S_LACT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_ctl = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_simple = 1'b1;
                    cmd.emit_code = code_reg;
                    state_next = S_IDLE;
                end
            end
            S_WSCAN:
            begin
                // No used slot remains only when nothing was reported yet.
                if (!sts.rest_any)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit_simple = 1'b1;
                        cmd.emit_code = ST_OK;
                        state_next = S_IDLE;
                    end
                end
                else if (sts.cur_used)
                begin
                    if (sts.out_free)
                    begin
                        cmd.rd_issue = 1'b1;
                        state_next = S_WLOAD;
                    end
                end
                else
                    cmd.idx_inc = 1'b1;
            end
            S_WLOAD:
            begin
                cmd.emit_entry = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next = sts.entry_last ? S_IDLE : S_WSCAN;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg <= code_next;
        end
    end

endmodule
